// ===== sv/alst_pkg.sv =====
// Shared types, codes and defaults for the array list engine.
`default_nettype none

package alst_pkg;

    // Default sizes of the list store.
    localparam int CAPACITY_DEF      = 32;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // A readout emits at most this many entries.
    localparam int MAX_RESULTS = 32;

    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Fixed widths of the item fields.
    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 6;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 6;

    // Action codes on the input.
    localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    // Operation after decode; unused action codes become a no-op.
    typedef enum logic [2:0] {
        OP_APPEND,
        OP_INSERT,
        OP_DELETE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    // Decoded command carried through the queue.
    typedef struct packed {
        t_op                   op;
        logic                  pos_zero;
        logic [POSITION_W-1:0] position;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/alst_front.sv =====
// Front end: decodes an accepted item into a command for the queue.
`default_nettype none

module alst_front import alst_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                     i_accept,
    input  wire logic [ACTION_W-1:0]      i_action,
    input  wire logic [POSITION_W-1:0]    i_position,
    input  wire logic [VALUE_W-1:0]       i_value,
    output logic                          o_push,
    output t_cmd                          o_cmd,
    output logic [ELEMENT_WIDTH-1:0]      o_value
);

    logic [ELEMENT_WIDTH+VALUE_W-1:0] value_ext;

    assign o_push = i_accept;

    // Map the action code onto an operation; codes without meaning do nothing.
    always_comb begin
        unique case (i_action)
            ACT_APPEND: o_cmd.op = OP_APPEND;
            ACT_INSERT: o_cmd.op = OP_INSERT;
            ACT_DELETE: o_cmd.op = OP_DELETE;
            ACT_CLEAR:  o_cmd.op = OP_CLEAR;
            ACT_READ:   o_cmd.op = OP_READ;
            default:    o_cmd.op = OP_NOP;
        endcase
        o_cmd.pos_zero = (i_position == '0);
        o_cmd.position = i_position;
    end

    // Keep only the low element bits of the value; wider elements are zero filled.
    assign value_ext = {{ELEMENT_WIDTH{1'b0}}, i_value};
    assign o_value   = value_ext[ELEMENT_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== sv/alst_queue.sv =====
// Small command queue that decouples the front end from the list back end.
`default_nettype none

module alst_queue import alst_pkg::*; #(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire t_cmd                     i_cmd,
    input  wire logic [ELEMENT_WIDTH-1:0] i_value,
    input  wire logic                     i_pop,
    output logic                          o_full,
    output logic                          o_avail,
    output t_cmd                          o_cmd,
    output logic [ELEMENT_WIDTH-1:0]      o_value
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd                     r_cmd [QUEUE_DEPTH];
    logic [ELEMENT_WIDTH-1:0] r_val [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr_ptr;
    logic [PTR_W-1:0]         r_rd_ptr;
    logic [FILL_W-1:0]        r_fill;
    logic                     do_push;
    logic                     do_pop;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_avail = (r_fill != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;
    assign o_cmd   = r_cmd[r_rd_ptr];
    assign o_value = r_val[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_cmd[r_wr_ptr] <= i_cmd;
            r_val[r_wr_ptr] <= i_value;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/alst_back.sv =====
// Back end: list cells with parallel shift, count, readout sequencer and result register.
`default_nettype none

module alst_back import alst_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_avail,
    input  wire t_cmd                     i_cmd,
    input  wire logic [ELEMENT_WIDTH-1:0] i_value,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [VALUE_W-1:0]            o_value_out,
    output logic [INDEX_W-1:0]            o_index_out,
    output logic [COUNT_W-1:0]            o_count,
    output logic                          o_is_empty,
    output logic                          o_is_full,
    output logic                          o_last
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(CAPACITY);
    localparam int XW  = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

    typedef enum logic {
        S_RUN,
        S_READ
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [IW-1:0]            r_rd_idx;
    logic [IW-1:0]            n_rd_idx;
    logic                     r_valid;
    logic                     n_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [VALUE_W-1:0]       r_value;
    logic [VALUE_W-1:0]       n_value;
    logic [INDEX_W-1:0]       r_index;
    logic [INDEX_W-1:0]       n_index;
    logic [COUNT_W-1:0]       r_count_out;
    logic                     r_empty;
    logic                     r_full;
    logic                     r_last;
    logic                     n_last;

    logic [ELEMENT_WIDTH-1:0] r_cells [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] up_src  [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] dn_src  [CAPACITY];

    logic [XW-1:0]            cnt_x;
    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            pos_m1;
    logic [XW-1:0]            idx1_x;
    logic [XW-1:0]            lim_x;
    logic [XW-1:0]            ncnt_x;
    logic [IW-1:0]            rd_addr;
    logic [ELEMENT_WIDTH-1:0] rd_data;
    logic [ELEMENT_WIDTH+VALUE_W-1:0] rd_ext;
    logic                     at_capacity;
    logic                     no_entries;
    logic                     rd_last;
    logic                     do_append;
    logic                     do_insert;
    logic                     do_delete;

    // Position and count arithmetic in a common width.
    assign cnt_x  = XW'(r_count);
    assign pos_x  = XW'(i_cmd.position);
    assign pos_m1 = pos_x - XW'(1);
    assign idx1_x = XW'(r_rd_idx) + XW'(1);
    assign lim_x  = (cnt_x > XW'(MAX_RESULTS)) ? XW'(MAX_RESULTS) : cnt_x;
    assign rd_last     = (idx1_x == lim_x);
    assign at_capacity = (r_count == CW'(CAPACITY));
    assign no_entries  = (r_count == '0);

    // Single read port: the delete position, or the readout index.
    assign rd_addr = (r_state == S_READ) ? r_rd_idx : pos_m1[IW-1:0];
    assign rd_data = r_cells[rd_addr];
    assign rd_ext  = {{VALUE_W{1'b0}}, rd_data};

    assign o_pop = (r_state == S_RUN) && i_avail;

    // Sequencer: one command per cycle outside a readout, a readout walks the cells.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_value   = '0;
        n_index   = '0;
        n_last    = 1'b1;
        do_append = 1'b0;
        do_insert = 1'b0;
        do_delete = 1'b0;
        unique case (r_state)
            S_RUN: begin
                if (i_avail) begin
                    n_valid = 1'b1;
                    unique case (i_cmd.op)
                        OP_APPEND: begin
                            if (at_capacity) begin
                                n_status = ST_FULL;
                            end else begin
                                do_append = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_INSERT: begin
                            priority if (at_capacity) begin
                                n_status = ST_FULL;
                            end else if (i_cmd.pos_zero || pos_x > cnt_x + XW'(1)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                do_insert = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            priority if (no_entries) begin
                                n_status = ST_EMPTY;
                            end else if (i_cmd.pos_zero || pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                do_delete = 1'b1;
                                n_value   = rd_ext[VALUE_W-1:0];
                                n_count   = r_count - CW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_READ: begin
                            if (no_entries) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_valid  = 1'b0;
                                n_rd_idx = '0;
                                n_state  = S_READ;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_value = rd_ext[VALUE_W-1:0];
                n_index = idx1_x[INDEX_W-1:0];
                n_last  = rd_last;
                if (rd_last) begin
                    n_state = S_RUN;
                end else begin
                    n_rd_idx = r_rd_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    assign ncnt_x = XW'(n_count);

    // State, count and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RUN;
            r_count  <= '0;
            r_rd_idx <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_valid  <= n_valid;
        end
        r_status    <= n_status;
        r_value     <= n_value;
        r_index     <= n_index;
        r_count_out <= ncnt_x[COUNT_W-1:0];
        r_empty     <= (n_count == '0);
        r_full      <= (n_count == CW'(CAPACITY));
        r_last      <= n_last;
    end

    // List cells: each takes the new value, its lower or its upper neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [XW-1:0] GX = XW'(g);

        if (g == 0) begin : g_first
            assign up_src[g] = '0;
        end else begin : g_up
            assign up_src[g] = r_cells[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign dn_src[g] = r_cells[g];
        end else begin : g_dn
            assign dn_src[g] = r_cells[g+1];
        end

        always_ff @(posedge i_clk) begin
            priority if (do_append && GX == cnt_x) begin
                r_cells[g] <= i_value;
            end else if (do_insert && GX == pos_m1) begin
                r_cells[g] <= i_value;
            end else if (do_insert && GX > pos_m1) begin
                r_cells[g] <= up_src[g];
            end else if (do_delete && GX >= pos_m1) begin
                r_cells[g] <= dn_src[g];
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_index_out = r_index;
    assign o_count     = r_count_out;
    assign o_is_empty  = r_empty;
    assign o_is_full   = r_full;
    assign o_last      = r_last;

endmodule

`default_nettype wire

// ===== sv/array_list_engine.sv =====
// Top level of the array list engine: front end, command queue and list back end.
//
// Usage: drive i_action, i_position and i_value and raise start; the item is taken at
// a rising edge where start is high and busy is low. busy is high only while the
// two-entry command queue is full.
// Results leave on the o_ ports for one cycle each, marked by o_valid; the receiver
// cannot hold them off. o_last marks the final result of an item.
// Path: a taken item is written into the command queue; the back end takes it from there
// and registers its result, and a readout enters its read state before it registers its
// entries. Items waiting in the queue add their wait.
// Append, insert, delete, clear and unused codes need no extra back-end state, since all
// cells shift in parallel; a readout gives its entries one by one, up to MAX_RESULTS
// entries, through the single cell read port, and pops no queued item until it is done.
// An empty readout gives one result with the empty status.
// Reset (synchronous, active low) empties the queue and sets the count to zero; cell
// contents are not cleared and are never read above the count.
`default_nettype none

module array_list_engine import alst_pkg::*; #(
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ACTION_W-1:0]   i_action,
    input  wire logic [POSITION_W-1:0] i_position,
    input  wire logic [VALUE_W-1:0]    i_value,
    output logic                       o_valid,
    output logic [1:0]                 o_status,
    output logic [VALUE_W-1:0]         o_value_out,
    output logic [INDEX_W-1:0]         o_index_out,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic                       o_last
);

    logic                     accept;
    logic                     push;
    t_cmd                     front_cmd;
    logic [ELEMENT_WIDTH-1:0] front_value;
    logic                     q_full;
    logic                     q_avail;
    t_cmd                     q_cmd;
    logic [ELEMENT_WIDTH-1:0] q_value;
    logic                     pop;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // Decode of incoming items.
    alst_front #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_front (
        .i_accept   (accept),
        .i_action   (i_action),
        .i_position (i_position),
        .i_value    (i_value),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .o_value    (front_value)
    );

    // Command queue.
    alst_queue #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_value (front_value),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_avail (q_avail),
        .o_cmd   (q_cmd),
        .o_value (q_value)
    );

    // List storage and execution.
    alst_back #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .i_cmd       (q_cmd),
        .i_value     (q_value),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_index_out (o_index_out),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the array list engine: directed table, then random requests.
`default_nettype none

module tb_top;
    import alst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_CAP      = CAPACITY_DEF;
    localparam int unsigned RANDOM_ITEMS  = 255;
    localparam int unsigned CALM_TAIL     = 40;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // Action codes the block treats as a no-op.
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    // Random request mixes.
    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_ANY, MIX_FILL } mix_t;

    // One result of the list, in port order.
    typedef struct packed {
        t_status               status;
        logic [VALUE_W-1:0]    value_out;
        logic [INDEX_W-1:0]    index_out;
        logic [COUNT_W-1:0]    count;
        logic                  is_empty;
        logic                  is_full;
        logic                  last;
    } list_result_t;

    // One row of the directed plan; a typed row carries its own single result.
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POSITION_W-1:0] position;
        logic [VALUE_W-1:0]    value;
        logic                  typed;
        t_status               status;
        logic [VALUE_W-1:0]    value_out;
        logic [COUNT_W-1:0]    count;
    } plan_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [ACTION_W-1:0]   i_action;
    logic [POSITION_W-1:0] i_position;
    logic [VALUE_W-1:0]    i_value;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic [VALUE_W-1:0]    o_value_out;
    logic [INDEX_W-1:0]    o_index_out;
    logic [COUNT_W-1:0]    o_count;
    logic                  o_is_empty;
    logic                  o_is_full;
    logic                  o_last;

    array_list_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_index_out (o_index_out),
        .o_count     (o_count),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the list contents and the results still owed by the block.
    logic [VALUE_W-1:0] list_cells [LIST_CAP];
    int unsigned        list_len;
    list_result_t       owed_results [$];
    int unsigned        error_count;
    int unsigned        cycle_count;

    // Builds one result around the current list length.
    function automatic list_result_t list_result(t_status st, logic [VALUE_W-1:0] v,
                                                 logic [INDEX_W-1:0] idx, logic fin);
        list_result_t r;
        r.status    = st;
        r.value_out = v;
        r.index_out = idx;
        r.count     = COUNT_W'(list_len);
        r.is_empty  = (list_len == 0);
        r.is_full   = (list_len == LIST_CAP);
        r.last      = fin;
        return r;
    endfunction

    // Applies one accepted request to the mirror and queues the results it owes.
    function automatic void apply_request(logic [ACTION_W-1:0] act,
                                          logic [POSITION_W-1:0] pos,
                                          logic [VALUE_W-1:0] val);
        int unsigned        p;
        int unsigned        n;
        logic [VALUE_W-1:0] removed;
        p = pos;
        case (act)
            ACT_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    owed_results.push_back(list_result(ST_FULL, '0, '0, 1'b1));
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                    owed_results.push_back(list_result(ST_OK, '0, '0, 1'b1));
                end
            end
            ACT_INSERT: begin
                if (list_len >= LIST_CAP) begin
                    owed_results.push_back(list_result(ST_FULL, '0, '0, 1'b1));
                end else if (p < 1 || p > list_len + 1) begin
                    owed_results.push_back(list_result(ST_BADPOS, '0, '0, 1'b1));
                end else begin
                    for (int i = list_len; i >= int'(p); i--) list_cells[i] = list_cells[i-1];
                    list_cells[p-1] = val;
                    list_len++;
                    owed_results.push_back(list_result(ST_OK, '0, '0, 1'b1));
                end
            end
            ACT_DELETE: begin
                if (list_len == 0) begin
                    owed_results.push_back(list_result(ST_EMPTY, '0, '0, 1'b1));
                end else if (p < 1 || p > list_len) begin
                    owed_results.push_back(list_result(ST_BADPOS, '0, '0, 1'b1));
                end else begin
                    removed = list_cells[p-1];
                    for (int i = p - 1; i + 1 < int'(list_len); i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                    owed_results.push_back(list_result(ST_OK, removed, '0, 1'b1));
                end
            end
            ACT_CLEAR: begin
                list_len = 0;
                owed_results.push_back(list_result(ST_OK, '0, '0, 1'b1));
            end
            ACT_READ: begin
                n = (list_len > MAX_RESULTS) ? MAX_RESULTS : list_len;
                if (n == 0) begin
                    owed_results.push_back(list_result(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (int unsigned i = 0; i < n; i++)
                        owed_results.push_back(list_result(ST_OK, list_cells[i],
                                                           INDEX_W'(i + 1), i + 1 == n));
                end
            end
            default: begin
                owed_results.push_back(list_result(ST_OK, '0, '0, 1'b1));
            end
        endcase
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    // Compares each strobed result with the oldest owed one.
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d value=%h count=%0d",
                                          o_status, o_value_out, o_count));
            end else begin
                want = owed_results.pop_front();
                if (o_status != want.status)
                    report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_value_out != want.value_out)
                    report_mismatch($sformatf("value_out got %h want %h",
                                              o_value_out, want.value_out));
                if (o_index_out != want.index_out)
                    report_mismatch($sformatf("index_out got %0d want %0d",
                                              o_index_out, want.index_out));
                if (o_count != want.count)
                    report_mismatch($sformatf("count got %0d want %0d", o_count, want.count));
                if (o_is_empty != want.is_empty)
                    report_mismatch($sformatf("is_empty got %0b want %0b",
                                              o_is_empty, want.is_empty));
                if (o_is_full != want.is_full)
                    report_mismatch($sformatf("is_full got %0b want %0b",
                                              o_is_full, want.is_full));
                if (o_last != want.last)
                    report_mismatch($sformatf("last got %0b want %0b", o_last, want.last));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one item from a falling edge and returns at the falling edge after it is taken.
    task automatic drive_item(logic [ACTION_W-1:0] act, logic [POSITION_W-1:0] pos,
                              logic [VALUE_W-1:0] val);
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        start      <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_request(act, pos, val);
        @(negedge i_clk);
    endtask

    // Sender gap with junk on the fields.
    task automatic hold_off(int unsigned cycles);
        start      <= 1'b0;
        i_action   <= ACTION_W'($urandom);
        i_position <= POSITION_W'($urandom);
        i_value    <= $urandom;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Holds the sender until every owed result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (owed_results.size() != 0) @(negedge i_clk);
    endtask

    // Element values biased toward the edges of the word.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] one_hot;
        one_hot = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // A position the list will refuse for insert (is_insert) or delete.
    function automatic logic [POSITION_W-1:0] bad_position(bit is_insert);
        int unsigned lo;
        lo = is_insert ? list_len + 2 : list_len + 1;
        if ($urandom_range(0, 2) == 0) return '0;
        return POSITION_W'($urandom_range(lo, (1 << POSITION_W) - 1));
    endfunction

    plan_row_t plan [25];

    initial begin
        mix_t                  mix;
        int unsigned           sent;
        int unsigned           run_len;
        int unsigned           dice;
        bit                    gappy;
        logic [ACTION_W-1:0]   act;
        logic [POSITION_W-1:0] pos;

        // Known values on every input while reset is held.
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_action    = '0;
        i_position  = '0;
        i_value     = '0;
        list_len    = 0;
        error_count = 0;
        cycle_count = 0;
        foreach (list_cells[i]) list_cells[i] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed plan: empty-list cases, bad positions, shifts, no-ops, readouts.
        plan = '{
            '{ACT_READ,     6'd0,  32'h0,        1'b1, ST_EMPTY,  32'h0,        6'd0},
            '{ACT_DELETE,   6'd1,  32'h0,        1'b1, ST_EMPTY,  32'h0,        6'd0},
            '{ACT_CLEAR,    6'd0,  32'h0,        1'b1, ST_OK,     32'h0,        6'd0},
            '{ACT_INSERT,   6'd0,  32'h1,        1'b1, ST_BADPOS, 32'h0,        6'd0},
            '{ACT_INSERT,   6'd2,  32'h1,        1'b1, ST_BADPOS, 32'h0,        6'd0},
            '{ACT_INSERT,   6'd1,  32'hFFFFFFFF, 1'b1, ST_OK,     32'h0,        6'd1},
            '{ACT_APPEND,   6'd0,  32'h0,        1'b1, ST_OK,     32'h0,        6'd2},
            '{ACT_INSERT,   6'd3,  32'hA5A5A5A5, 1'b1, ST_OK,     32'h0,        6'd3},
            '{ACT_INSERT,   6'd2,  32'h5A5A5A5A, 1'b1, ST_OK,     32'h0,        6'd4},
            '{ACT_INSERT,   6'd4,  32'h12345678, 1'b1, ST_OK,     32'h0,        6'd5},
            '{ACT_INSERT,   6'd63, 32'h0,        1'b1, ST_BADPOS, 32'h0,        6'd5},
            '{ACT_READ,     6'd0,  32'h0,        1'b0, ST_OK,     32'h0,        6'd0},
            '{ACT_DELETE,   6'd0,  32'h0,        1'b1, ST_BADPOS, 32'h0,        6'd5},
            '{ACT_DELETE,   6'd6,  32'h0,        1'b1, ST_BADPOS, 32'h0,        6'd5},
            '{ACT_DELETE,   6'd63, 32'h0,        1'b1, ST_BADPOS, 32'h0,        6'd5},
            '{ACT_DELETE,   6'd2,  32'h0,        1'b1, ST_OK,     32'h5A5A5A5A, 6'd4},
            '{ACT_DELETE,   6'd4,  32'h0,        1'b1, ST_OK,     32'hA5A5A5A5, 6'd3},
            '{ACT_DELETE,   6'd1,  32'h0,        1'b1, ST_OK,     32'hFFFFFFFF, 6'd2},
            '{ACT_SPARE_LO, 6'd1,  32'h0,        1'b1, ST_OK,     32'h0,        6'd2},
            '{ACT_SPARE_HI, 6'd1,  32'h0,        1'b1, ST_OK,     32'h0,        6'd2},
            '{ACT_READ,     6'd0,  32'h0,        1'b0, ST_OK,     32'h0,        6'd0},
            '{ACT_CLEAR,    6'd0,  32'h0,        1'b1, ST_OK,     32'h0,        6'd0},
            '{ACT_APPEND,   6'd0,  32'h80000000, 1'b1, ST_OK,     32'h0,        6'd1},
            '{ACT_READ,     6'd0,  32'h0,        1'b0, ST_OK,     32'h0,        6'd0},
            '{ACT_DELETE,   6'd1,  32'h0,        1'b1, ST_OK,     32'h80000000, 6'd0}
        };
        foreach (plan[k]) begin
            drive_item(plan[k].action, plan[k].position, plan[k].value);
            // A typed row's own result stands in for the computed one.
            if (plan[k].typed) begin
                void'(owed_results.pop_back());
                list_len = plan[k].count;
                owed_results.push_back(list_result(plan[k].status, plan[k].value_out,
                                                   '0, 1'b1));
            end
            if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
        end
        wait_drained();

        // Random runs; the first one is a fill run, mostly appends and inserts, aimed at full.
        sent = 0;
        mix  = MIX_FILL;
        while (sent < RANDOM_ITEMS) begin
            run_len = (mix == MIX_FILL) ? 45 : $urandom_range(8, 40);
            gappy   = ($urandom_range(0, 3) != 0);
            for (int unsigned k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                dice = $urandom_range(0, 99);
                act  = ACT_READ;
                pos  = POSITION_W'($urandom);
                case (mix)
                    MIX_FILL, MIX_GROW: begin
                        if (dice < 45) begin
                            act = ACT_APPEND;
                        end else if (dice < 80) begin
                            act = ACT_INSERT;
                            pos = POSITION_W'($urandom_range(1, list_len + 1));
                        end else if (dice < 87) begin
                            act = ACT_INSERT;
                            pos = bad_position(1'b1);
                        end else if (dice >= 95) begin
                            act = ACTION_W'($urandom);
                        end
                    end
                    MIX_SHRINK: begin
                        if (dice < 60) begin
                            act = ACT_DELETE;
                            pos = (list_len == 0) ? POSITION_W'($urandom_range(0, 2))
                                                  : POSITION_W'($urandom_range(1, list_len));
                        end else if (dice < 68) begin
                            act = ACT_DELETE;
                            pos = bad_position(1'b0);
                        end else if (dice < 70) begin
                            act = ACT_CLEAR;
                        end else if (dice >= 80) begin
                            act = ACTION_W'($urandom);
                        end
                    end
                    default: begin
                        act = ACTION_W'($urandom);
                    end
                endcase
                drive_item(act, pos, pick_value());
                sent++;
                if (gappy && RANDOM_ITEMS - sent > CALM_TAIL && $urandom_range(0, 2) == 0)
                    hold_off($urandom_range(1, 12));
            end
            if (RANDOM_ITEMS - sent > CALM_TAIL && $urandom_range(0, 2) == 0) wait_drained();
            case ($urandom_range(0, 9))
                0, 1, 2: mix = MIX_GROW;
                3, 4, 5: mix = MIX_SHRINK;
                6:       mix = MIX_FILL;
                default: mix = MIX_ANY;
            endcase
        end

        // Let every owed result arrive, then wait on for stray output.
        start <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/alst_pkg.sv
sv/alst_front.sv
sv/alst_queue.sv
sv/alst_back.sv
sv/array_list_engine.sv
dv/tb_top.sv
